// ===== sv/multi_queue_linked_fifo_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the linked-list multi-queue manager
// Clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef MULTI_QUEUE_LINKED_FIFO_CORE_MACROS_SVH
`define MULTI_QUEUE_LINKED_FIFO_CORE_MACROS_SVH

// Same-cycle implication.
`define MQLF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mqlf assertion failed");

// Next-cycle implication.
`define MQLF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mqlf assertion failed");

`endif

// ===== sv/mqlf_pkg.sv =====
// ---------------------------------------------------------------------------
// mqlf_pkg
// Shared types and codes of the linked-list multi-queue manager.
// ---------------------------------------------------------------------------
`default_nettype none

package mqlf_pkg;

	localparam int QID_W   = 3;
	localparam int KIND_W  = 8;
	localparam int BUF_W   = 8;
	localparam int DEPTH_W = 9;

	localparam logic FUNC_SEND    = 1'b0;
	localparam logic FUNC_RECV    = 1'b1;
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_EMPTY = 1'b1;

	typedef struct packed {
		logic              func;
		logic [QID_W-1:0]  queue_id;
		logic [KIND_W-1:0] msg_kind;
		logic [BUF_W-1:0]  buffer_index;
	} req_t;

	typedef struct packed {
		logic               status;
		logic [KIND_W-1:0]  out_kind;
		logic [BUF_W-1:0]   out_buffer;
		logic [DEPTH_W-1:0] queue_depth;
	} rsp_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic capture;  // latch request, launch memory read
		logic commit;   // update queue state, load result register
	} cmd_t;

endpackage

`default_nettype wire

// ===== sv/mqlf_ctrl.sv =====
// ---------------------------------------------------------------------------
// mqlf_ctrl
// Two-state controller: capture a request, then commit it once the result
// register is free. Owns both handshakes.
// ---------------------------------------------------------------------------
`default_nettype none

module mqlf_ctrl
	import mqlf_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  req_valid,
	output logic req_stall,
	output logic rsp_valid,
	input  wire  rsp_stall,
	output cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   rsp_free;

	assign rsp_free    = !rsp_valid_q || !rsp_stall;
	assign req_stall   = (state_q != ST_IDLE);
	assign cmd.capture = (state_q == ST_IDLE) && req_valid;
	assign cmd.commit  = (state_q == ST_EXEC) && rsp_free;
	assign rsp_valid   = rsp_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (rsp_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ===== sv/mqlf_datapath.sv =====
// ---------------------------------------------------------------------------
// mqlf_datapath
// Per-queue head/tail/count registers, link and kind memories, result
// register.
// ---------------------------------------------------------------------------
`default_nettype none

module mqlf_datapath
	import mqlf_pkg::*;
#(
	parameter int NUM_QUEUES = 8,
	parameter int NUM_SLOTS  = 256
) (
	input  wire  clk,
	input  wire  arst_n,
	input  cmd_t cmd,
	input  req_t req,
	output rsp_t rsp
);

	// Queue ids and slot indexes are limited by their field widths.
	localparam int NQ_EFF    = (NUM_QUEUES < (1 << QID_W)) ? NUM_QUEUES : (1 << QID_W);
	localparam int MEM_DEPTH = (NUM_SLOTS < (1 << BUF_W)) ? NUM_SLOTS : (1 << BUF_W);
	localparam int QW        = (NQ_EFF > 1) ? $clog2(NQ_EFF) : 1;
	localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int CW        = $clog2(NUM_SLOTS + 1);
	localparam int DW        = (CW > DEPTH_W) ? CW : DEPTH_W;

	logic [AW-1:0]     head_q [NQ_EFF];
	logic [AW-1:0]     tail_q [NQ_EFF];
	logic [CW-1:0]     cnt_q  [NQ_EFF];
	logic [AW-1:0]     link_mem [MEM_DEPTH];
	logic [KIND_W-1:0] kind_mem [MEM_DEPTH];

	req_t              op_q;
	logic [AW-1:0]     link_rd_q;
	logic [KIND_W-1:0] kind_rd_q;
	rsp_t              rsp_q;

	logic [QW-1:0]     req_qi, qi;
	logic [AW-1:0]     rd_addr, slot, head_cur, tail_cur, head_new;
	logic [CW-1:0]     cnt_cur, cnt_new;
	logic [DW-1:0]     depth_w;
	logic              q_ok, slot_ok;
	logic              head_we, tail_we, cnt_we, kind_we, link_we;
	rsp_t              res;

	assign req_qi  = QW'(req.queue_id);
	assign rd_addr = head_q[req_qi];
	assign qi      = QW'(op_q.queue_id);
	assign slot    = AW'(op_q.buffer_index);
	assign q_ok    = int'(op_q.queue_id) < NQ_EFF;
	assign slot_ok = int'(op_q.buffer_index) < NUM_SLOTS;
	assign head_cur = head_q[qi];
	assign tail_cur = tail_q[qi];
	assign cnt_cur  = cnt_q[qi];

	always_comb begin
		res      = '0;
		head_we  = 1'b0;
		tail_we  = 1'b0;
		cnt_we   = 1'b0;
		kind_we  = 1'b0;
		link_we  = 1'b0;
		head_new = slot;
		cnt_new  = cnt_cur;
		depth_w  = '0;
		if (!q_ok) begin
			res.status = (op_q.func == FUNC_RECV) ? STATUS_EMPTY : STATUS_OK;
		end else if (op_q.func == FUNC_SEND) begin
			if (slot_ok) begin
				kind_we = 1'b1;
				tail_we = 1'b1;
				cnt_we  = 1'b1;
				if (cnt_cur == '0) head_we = 1'b1;
				else link_we = 1'b1;
				if (int'(cnt_cur) < NUM_SLOTS) cnt_new = CW'(cnt_cur + 1'b1);
			end
			depth_w           = DW'(cnt_new);
			res.queue_depth   = depth_w[DEPTH_W-1:0];
		end else if (cnt_cur == '0) begin
			res.status = STATUS_EMPTY;
		end else begin
			// Pop the head; advance it only if more entries remain.
			head_new        = link_rd_q;
			head_we         = (cnt_cur > CW'(1));
			cnt_we          = 1'b1;
			cnt_new         = CW'(cnt_cur - 1'b1);
			depth_w         = DW'(cnt_new);
			res.queue_depth = depth_w[DEPTH_W-1:0];
			res.out_buffer  = BUF_W'(head_cur);
			res.out_kind    = kind_rd_q;
		end
	end

	// Request latch and memory read port.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q      <= req;
			link_rd_q <= link_mem[rd_addr];
			kind_rd_q <= kind_mem[rd_addr];
		end
	end

	// Memory write port.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (kind_we) kind_mem[slot] <= op_q.msg_kind;
			if (link_we) link_mem[tail_cur] <= slot;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (head_we) head_q[qi] <= head_new;
			if (tail_we) tail_q[qi] <= slot;
			rsp_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NQ_EFF; i++) cnt_q[i] <= '0;
		end else if (cmd.commit && cnt_we) begin
			cnt_q[qi] <= cnt_new;
		end
	end

	assign rsp = rsp_q;

endmodule

`default_nettype wire

// ===== sv/multi_queue_linked_fifo_core.sv =====
// A transferred request is captured (reading link/kind) and then committed (writing),
// loading the result register; no new request is taken until that commit.
// A stalled result holds the next commit and with it the request side.
// Reset: arst_n clears queue counts and handshake state; memories and
//   head/tail pointers are not cleared, so no clearing pass is needed.
// ---------------------------------------------------------------------------
// multi_queue_linked_fifo_core
// Several FIFO queues kept as linked lists through one shared slot pool.
// ---------------------------------------------------------------------------
`default_nettype none

module multi_queue_linked_fifo_core
	import mqlf_pkg::*;
#(
	parameter int NUM_QUEUES = 8,
	parameter int NUM_SLOTS  = 256
) (
	input  wire  clk,
	input  wire  arst_n,
	// Request channel: one transfer per queue operation.
	input  wire  req_valid,
	output logic req_stall,
	input  req_t req,
	// Result channel: one transfer per request, in order.
	output logic rsp_valid,
	input  wire  rsp_stall,
	output rsp_t rsp
);

	cmd_t cmd;

	// Controller: IDLE takes a request transfer and launches the read of
	// the addressed head's link and kind; EXEC commits once the result
	// register is empty or being drained.
	mqlf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	// Datapath: on commit, append to tail (send) or pop the head (receive),
	// update the count with saturation, and load the result register.
	mqlf_datapath #(
		.NUM_QUEUES (NUM_QUEUES),
		.NUM_SLOTS  (NUM_SLOTS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

// ===== sv/mqlf_checker.sv =====
// ---------------------------------------------------------------------------
// mqlf_checker
// Port-level checks of the multi-queue manager, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "multi_queue_linked_fifo_core_macros.svh"

module mqlf_checker
	import mqlf_pkg::*;
(
	input wire  clk,
	input wire  arst_n,
	input wire  req_valid,
	input wire  req_stall,
	input wire  rsp_valid,
	input wire  rsp_stall,
	input rsp_t rsp
);

	// Hold a stalled result.
	`MQLF_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

	// One request in flight: a transfer closes the request side.
	`MQLF_ASSERT_NEXT(a_req_busy, req_valid && !req_stall, req_stall)

	// An empty answer carries no slot, no kind and zero depth.
	`MQLF_ASSERT_NOW(a_empty_zero, rsp_valid && (rsp.status == STATUS_EMPTY),
		(rsp.out_kind == '0) && (rsp.out_buffer == '0) && (rsp.queue_depth == '0))

	// A new result only follows a busy execute cycle.
	`MQLF_ASSERT_NOW(a_rsp_after_exec, $rose(rsp_valid), $past(req_stall))

endmodule

bind multi_queue_linked_fifo_core mqlf_checker u_mqlf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

`default_nettype wire
